FILE: rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned POS_W   = 7;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CNT_W   = 7;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;
    localparam mode_t MODE_LOCATE = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/positional_list_engine.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held packed in a
// single-port-write RAM with a registered read and a fill count. Each
// request (insert, delete, locate or an unused mode code) produces one
// result. Entries are moved or scanned one per cycle through the RAM.
// An insert at the end, a delete of the last entry, a locate on an empty
// list and a rejected request take no RAM reads. A wait on m_tready holds
// the result in the finish state. The next request is taken in the cycle
// after the result is registered.
module positional_list_engine #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  wire  [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [0] ok, [7:1] found_position, [14:8] count, [15] zero
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic                   m_valid_reg, m_valid_next;

    ple_pkg::mode_t         op_reg, op_next;
    ple_pkg::pos_t          pos_reg, pos_next;
    ple_pkg::value_t        val_reg, val_next;
    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic [CW-1:0]          rd_left_reg, rd_left_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic                   res_ok_reg, res_ok_next;
    ple_pkg::pos_t          res_pos_reg, res_pos_next;
    logic                   m_ok_reg, m_ok_next;
    ple_pkg::pos_t          m_pos_reg, m_pos_next;
    logic [ple_pkg::CNT_W-1:0] m_cnt_reg, m_cnt_next;

    ple_pkg::value_t        entries_mem [CAPACITY];
    ple_pkg::value_t        rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    ple_pkg::value_t        mem_wdata;
    logic                   rd_en;

    ple_pkg::mode_t         in_mode;
    logic [XW-1:0]          in_pos_x;
    logic [XW-1:0]          cnt_x;
    logic [XW-1:0]          cur_pos_x;
    logic                   s_fire;
    logic                   stop;

    assign in_mode   = s_tuser;
    assign in_pos_x  = XW'(s_tdata[6:0]);
    assign cnt_x     = XW'(count_reg);
    assign cur_pos_x = XW'(pos_reg);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_cnt_reg, m_pos_reg, m_ok_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entries_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= entries_mem[rd_addr_reg];
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        pend_addr_next = pend_addr_reg;
        res_ok_next    = res_ok_reg;
        res_pos_next   = res_pos_reg;
        m_ok_next      = m_ok_reg;
        m_pos_next     = m_pos_reg;
        m_cnt_next     = m_cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rdata_reg;
        rd_en          = 1'b0;
        stop           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next      = in_mode;
                    pos_next     = s_tdata[6:0];
                    val_next     = s_tdata[38:7];
                    pend_next    = 1'b0;
                    res_ok_next  = 1'b0;
                    res_pos_next = '0;
                    state_next   = ST_FINISH;
                    case (in_mode)
                        ple_pkg::MODE_INSERT: begin
                            if (in_pos_x != '0 && in_pos_x <= cnt_x + 1'b1 &&
                                cnt_x != XW'(CAPACITY)) begin
                                rd_addr_next = AW'(cnt_x - 1'b1);
                                rd_left_next = CW'(cnt_x - in_pos_x + 1'b1);
                                state_next   = ST_SCAN;
                            end
                        end
                        ple_pkg::MODE_DELETE: begin
                            if (in_pos_x != '0 && in_pos_x <= cnt_x) begin
                                rd_addr_next = AW'(in_pos_x);
                                rd_left_next = CW'(cnt_x - in_pos_x);
                                state_next   = ST_SCAN;
                            end
                        end
                        ple_pkg::MODE_LOCATE: begin
                            rd_addr_next = '0;
                            rd_left_next = count_reg;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (pend_reg) begin
                    case (op_reg)
                        ple_pkg::MODE_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + 1'b1;
                        end
                        ple_pkg::MODE_DELETE: begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - 1'b1;
                        end
                        default: begin
                            if (rdata_reg == val_reg) begin
                                stop         = 1'b1;
                                res_ok_next  = 1'b1;
                                res_pos_next = ple_pkg::POS_W'(XW'(pend_addr_reg) + 1'b1);
                                pend_next    = 1'b0;
                                state_next   = ST_FINISH;
                            end
                        end
                    endcase
                end
                if (!stop) begin
                    if (rd_left_reg != '0) begin
                        rd_en          = 1'b1;
                        rd_left_next   = rd_left_reg - 1'b1;
                        pend_next      = 1'b1;
                        pend_addr_next = rd_addr_reg;
                        if (op_reg == ple_pkg::MODE_INSERT) begin
                            rd_addr_next = rd_addr_reg - 1'b1;
                        end else begin
                            rd_addr_next = rd_addr_reg + 1'b1;
                        end
                    end else begin
                        pend_next = 1'b0;
                        if (!pend_reg) begin
                            state_next = ST_FINISH;
                            case (op_reg)
                                ple_pkg::MODE_INSERT: begin
                                    mem_we      = 1'b1;
                                    mem_waddr   = AW'(cur_pos_x - 1'b1);
                                    mem_wdata   = val_reg;
                                    count_next  = count_reg + 1'b1;
                                    res_ok_next = 1'b1;
                                end
                                ple_pkg::MODE_DELETE: begin
                                    count_next  = count_reg - 1'b1;
                                    res_ok_next = 1'b1;
                                end
                                default: begin
                                    res_ok_next  = 1'b0;
                                    res_pos_next = '0;
                                end
                            endcase
                        end
                    end
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_pos_next   = res_pos_reg;
                    m_cnt_next   = ple_pkg::CNT_W'(cnt_x);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        rd_addr_reg   <= rd_addr_next;
        rd_left_reg   <= rd_left_next;
        pend_addr_reg <= pend_addr_next;
        res_ok_reg    <= res_ok_next;
        res_pos_reg   <= res_pos_next;
        m_ok_reg      <= m_ok_next;
        m_pos_reg     <= m_pos_next;
        m_cnt_reg     <= m_cnt_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> !mem_we)
        else $error("RAM write outside a scan");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != ST_IDLE))
        else $error("request accepted but engine stayed idle");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |=> $stable(count_reg))
        else $error("fill count changed outside a scan");
`endif

endmodule

`default_nettype wire

FILE: sim/positional_list_engine_test.sv
`default_nettype none

module positional_list_engine_test;

    localparam int LIST_CAP       = 64;
    localparam int STUCK_LIMIT    = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int CALM_AFTER     = 620;
    localparam int SETTLE_CYCLES  = 100;

    // mode code with no operation behind it
    localparam ple_pkg::mode_t MODE_UNUSED = 2'd3;

    typedef struct packed {
        ple_pkg::mode_t  mode;
        ple_pkg::pos_t   position;
        ple_pkg::value_t value;
    } list_req_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] found_position;
        logic [6:0] count;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [6:0] position, [38:7] value, [39] zero
    logic [1:0]  s_tuser = '0;     // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [0] ok, [7:1] found_position, [14:8] count, [15] zero

    // list contents as the block should hold them, updated on request accept
    ple_pkg::value_t list_mem [LIST_CAP];
    int     list_len = 0;

    // fill level seen by the request generator, ahead of the block
    int     gen_len = 0;

    list_req_t    pending_reqs [$];
    list_result_t due_results [$];
    list_req_t    next_req;
    list_result_t got, want;

    int  reqs_queued = 0;
    int  reqs_taken = 0;
    int  results_seen = 0;
    int  errors = 0;
    int  stuck_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  req_took = 1'b0;
    bit  calm_tail = 1'b0;
    bit  long_hold_done = 1'b0;

    int  op_hits [3] = '{0, 0, 0};
    int  ok_hits = 0;
    int  peak_len = 0;
    int  full_rejects = 0;

    positional_list_engine #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic list_result_t apply_list_op(list_req_t r);
        list_result_t res;
        int k;
        int p;
        res = '0;
        p = int'(r.position);
        case (r.mode)
            ple_pkg::MODE_INSERT: begin
                op_hits[0]++;
                if (list_len >= LIST_CAP && p >= 1 && p <= list_len + 1) begin
                    full_rejects++;
                end
                if (p >= 1 && p <= list_len + 1 && list_len < LIST_CAP) begin
                    for (k = list_len; k > p - 1; k--) begin
                        list_mem[k] = list_mem[k - 1];
                    end
                    list_mem[p - 1] = r.value;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            ple_pkg::MODE_DELETE: begin
                op_hits[1]++;
                if (p >= 1 && p <= list_len) begin
                    for (k = p - 1; k + 1 < list_len; k++) begin
                        list_mem[k] = list_mem[k + 1];
                    end
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            ple_pkg::MODE_LOCATE: begin
                op_hits[2]++;
                for (k = 0; k < list_len; k++) begin
                    if (list_mem[k] == r.value) begin
                        res.found_position = 7'(k + 1);
                        res.ok = 1'b1;
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = 7'(list_len);
        if (res.ok) begin
            ok_hits++;
        end
        if (list_len > peak_len) begin
            peak_len = list_len;
        end
        return res;
    endfunction

    task automatic queue_op(ple_pkg::mode_t mode, int pos, ple_pkg::value_t value);
        list_req_t r;
        r.mode = mode;
        r.position = 7'(pos);
        r.value = value;
        if (mode == ple_pkg::MODE_INSERT && pos >= 1 && pos <= gen_len + 1 &&
            gen_len < LIST_CAP) begin
            gen_len++;
        end else if (mode == ple_pkg::MODE_DELETE && pos >= 1 && pos <= gen_len) begin
            gen_len--;
        end
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // ins_pct/del_pct set the operation mix; locate takes the rest
    task automatic queue_random_op(int ins_pct, int del_pct);
        int              roll;
        int              pos;
        ple_pkg::mode_t  mode;
        ple_pkg::value_t value;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            mode = ple_pkg::MODE_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            mode = ple_pkg::MODE_DELETE;
        end else begin
            mode = ple_pkg::MODE_LOCATE;
        end
        if ($urandom_range(0, 49) == 0) begin
            mode = MODE_UNUSED;
        end
        if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 7))
                0: value = 32'h8000_0000;
                1: value = 32'h7fff_ffff;
                2: value = 32'h0000_0000;
                3: value = 32'hffff_ffff;
                4: value = 32'h0000_0001;
                5: value = 32'h5555_5555;
                6: value = 32'haaaa_aaaa;
                default: value = 32'h0000_002a;
            endcase
        end else begin
            value = $urandom();
        end
        if ($urandom_range(0, 9) < 8 && mode == ple_pkg::MODE_INSERT) begin
            pos = $urandom_range(1, gen_len + 1);
        end else if ($urandom_range(0, 9) < 8 && mode == ple_pkg::MODE_DELETE &&
                     gen_len > 0) begin
            pos = $urandom_range(1, gen_len);
        end else begin
            pos = $urandom_range(0, 127);
        end
        queue_op(mode, pos, value);
    endtask

    task automatic wait_drained();
        while (results_seen < reqs_queued) begin
            @(negedge aclk);
        end
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_took) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                s_tuser  <= next_req.mode;
                s_tdata  <= {1'b0, next_req.value, next_req.position};
                s_tvalid <= 1'b1;
                if (!calm_tail && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 15);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver; one long hold-off lets the block back up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 120) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: predict on request accept, check on result accept
    always @(posedge aclk) begin
        req_took = 1'b0;
        if (aresetn) begin
            stuck_cycles++;
            if (s_tvalid && s_tready) begin
                req_took = 1'b1;
                stuck_cycles = 0;
                reqs_taken++;
                if (reqs_taken >= CALM_AFTER) begin
                    calm_tail = 1'b1;
                end
                due_results.push_back(apply_list_op({ple_pkg::mode_t'(s_tuser),
                                                     s_tdata[6:0], s_tdata[38:7]}));
            end
            if (m_tvalid && m_tready) begin
                stuck_cycles = 0;
                results_seen++;
                got.ok = m_tdata[0];
                got.found_position = m_tdata[7:1];
                got.count = m_tdata[14:8];
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result ok=%0d pos=%0d cnt=%0d",
                             $time, got.ok, got.found_position, got.count);
                end else begin
                    want = due_results.pop_front();
                    if (got.ok !== want.ok || got.found_position !== want.found_position ||
                        got.count !== want.count) begin
                        errors++;
                        $display("%0t: result %0d mismatch", $time, results_seen);
                        $display("%0t: exp ok=%0d pos=%0d cnt=%0d, act ok=%0d pos=%0d cnt=%0d",
                                 $time, want.ok, want.found_position, want.count,
                                 got.ok, got.found_position, got.count);
                    end
                end
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // empty list corners
        queue_op(ple_pkg::MODE_DELETE, 1, 32'h0000_0000);
        queue_op(ple_pkg::MODE_LOCATE, 0, 32'h0000_0000);
        queue_op(ple_pkg::MODE_INSERT, 0, 32'h1234_5678);
        queue_op(ple_pkg::MODE_INSERT, 2, 32'h1234_5678);
        queue_op(ple_pkg::MODE_INSERT, 127, 32'hffff_ffff);
        queue_op(MODE_UNUSED, 1, 32'h0000_0000);
        // build a short list with extreme values, front, back and middle; then locate and delete
        queue_op(ple_pkg::MODE_INSERT, 1, 32'h7fff_ffff);
        queue_op(ple_pkg::MODE_INSERT, 1, 32'h8000_0000);
        queue_op(ple_pkg::MODE_INSERT, 3, 32'h0000_0000);
        queue_op(ple_pkg::MODE_INSERT, 2, 32'hffff_ffff);
        queue_op(ple_pkg::MODE_INSERT, 2, 32'h0000_0000);
        queue_op(MODE_UNUSED, 2, 32'h7fff_ffff);
        queue_op(ple_pkg::MODE_LOCATE, 127, 32'h7fff_ffff);
        queue_op(ple_pkg::MODE_LOCATE, 0, 32'h8000_0000);
        queue_op(ple_pkg::MODE_LOCATE, 0, 32'h0000_0000);
        queue_op(ple_pkg::MODE_LOCATE, 0, 32'h1234_5678);
        queue_op(ple_pkg::MODE_DELETE, 0, 32'h0000_0000);
        queue_op(ple_pkg::MODE_DELETE, 6, 32'h0000_0000);
        queue_op(ple_pkg::MODE_DELETE, 127, 32'hffff_ffff);
        queue_op(ple_pkg::MODE_DELETE, 5, 32'h0000_0000);
        queue_op(ple_pkg::MODE_DELETE, 1, 32'h0000_0000);
        queue_op(ple_pkg::MODE_LOCATE, 0, 32'hffff_ffff);
        wait_drained();

        // fill up to capacity and hammer the full list
        repeat (200) queue_random_op(85, 10);
        wait_drained();
        // drain towards empty
        repeat (200) queue_random_op(10, 80);
        // mixed traffic; the tail of it runs without idling
        repeat (300) queue_random_op(40, 30);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (due_results.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, due_results.size());
        end
        $display("Covered %0d requests (%0d insert, %0d delete, %0d locate), %0d succeeded;",
                 reqs_taken, op_hits[0], op_hits[1], op_hits[2], ok_hits);
        $display("list peaked at %0d entries, %0d inserts refused on a full list, %0d errors.",
                 peak_len, full_rejects, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
